// ===== rtl/sts_pkg.sv =====
`timescale 1ns / 1ps
package sts_pkg;

    localparam int MAX_WORD_LEN = 12;
    localparam int WLEN_W = $clog2(MAX_WORD_LEN + 2);

    typedef enum logic [5:0] {
        S_START, S_IDENT, S_QMARK, S_TYPEID, S_NUM, S_NUM_DOT, S_NUM_DEC,
        S_NUM_E, S_NUM_ESIGN, S_NUM_EXP, S_STR_START, S_STR, S_STR_ML,
        S_STR_END, S_STR_BSL, S_VAR_DOLLAR, S_VAR_ID, S_DIV, S_LINE_CMT,
        S_BLK_TEXT, S_BLK_STAR, S_LESS, S_PRO0, S_PRO1, S_PRO2, S_PRO3,
        S_GREATER, S_GE, S_LE, S_ASSIGN, S_EQ2, S_EQ3, S_EXCL, S_NE2, S_NE3,
        S_LPAR, S_RPAR, S_MUL, S_PLUS, S_MINUS, S_DOT, S_LBR, S_RBR, S_COMMA,
        S_COLON, S_SEMI, S_END, S_DONE, S_ERR
    } scan_state_t;

    localparam logic [5:0] K_ID      = 6'd0;
    localparam logic [5:0] K_PROLOG  = 6'd24;
    localparam logic [5:0] K_KEYWORD = 6'd25;
    localparam logic [5:0] K_OPT     = 6'd47;
    localparam logic [5:0] K_END     = 6'd63;

    typedef logic [MAX_WORD_LEN*8-1:0] word_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] kind;
        logic       text;
        logic       err;
        logic       done;
    } scan_result_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] index;
    } word_match_t;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic scan_state_t string_next(input logic [7:0] b);
        scan_state_t r;
        if (b == "\"") r = S_STR_END;
        else if (b == 8'h5c) r = S_STR_BSL;
        else if (b > 8'd31 && b < 8'd128 && b != "$") r = S_STR;
        else if (b == 8'h0a) r = S_STR_ML;
        else r = S_ERR;
        return r;
    endfunction

    function automatic scan_state_t trans(input scan_state_t s, input logic [7:0] b);
        scan_state_t r;
        r = S_ERR;
        case (s)
            S_START:
            begin
                if (b == " " || b == 8'h09 || b == 8'h0a) r = S_START;
                else if (b == "$") r = S_VAR_DOLLAR;
                else if (is_letter(b) || b == "_") r = S_IDENT;
                else if (is_digit(b)) r = S_NUM;
                else
                begin
                    case (b)
                        "?": r = S_QMARK;
                        "(": r = S_LPAR;
                        ")": r = S_RPAR;
                        "*": r = S_MUL;
                        "+": r = S_PLUS;
                        "-": r = S_MINUS;
                        ">": r = S_GREATER;
                        "<": r = S_LESS;
                        "=": r = S_ASSIGN;
                        "/": r = S_DIV;
                        "\"": r = S_STR_START;
                        "!": r = S_EXCL;
                        ".": r = S_DOT;
                        "{": r = S_LBR;
                        "}": r = S_RBR;
                        ",": r = S_COMMA;
                        ":": r = S_COLON;
                        ";": r = S_SEMI;
                        default: r = S_ERR;
                    endcase
                end
            end
            S_IDENT: r = (is_letter(b) || is_digit(b) || b == "_") ? S_IDENT : S_ERR;
            S_QMARK: r = is_letter(b) ? S_TYPEID : ((b == ">") ? S_END : S_ERR);
            S_TYPEID: r = is_letter(b) ? S_TYPEID : S_ERR;
            S_NUM:
            begin
                if (is_digit(b)) r = S_NUM;
                else if (b == ".") r = S_NUM_DOT;
                else if (b == "e" || b == "E") r = S_NUM_E;
            end
            S_NUM_DOT: r = is_digit(b) ? S_NUM_DEC : S_ERR;
            S_NUM_DEC:
            begin
                if (is_digit(b)) r = S_NUM_DEC;
                else if (b == "e" || b == "E") r = S_NUM_E;
            end
            S_NUM_E:
            begin
                if (is_digit(b)) r = S_NUM_EXP;
                else if (b == "+" || b == "-") r = S_NUM_ESIGN;
            end
            S_NUM_ESIGN, S_NUM_EXP: r = is_digit(b) ? S_NUM_EXP : S_ERR;
            S_STR_START, S_STR, S_STR_ML: r = string_next(b);
            S_VAR_DOLLAR: r = (is_letter(b) || b == "_") ? S_VAR_ID : S_ERR;
            S_VAR_ID: r = (is_letter(b) || is_digit(b) || b == "_") ? S_VAR_ID : S_ERR;
            S_DIV:
            begin
                if (b == "*") r = S_BLK_TEXT;
                else if (b == "/") r = S_LINE_CMT;
            end
            S_LINE_CMT: r = (b == 8'h0a) ? S_START : S_LINE_CMT;
            S_BLK_TEXT: r = (b == "*") ? S_BLK_STAR : S_BLK_TEXT;
            S_BLK_STAR:
            begin
                if (b == "/") r = S_START;
                else if (b == "*") r = S_BLK_STAR;
                else r = S_BLK_TEXT;
            end
            S_LESS:
            begin
                if (b == "=") r = S_LE;
                else if (b == "?") r = S_PRO0;
            end
            S_PRO0: r = (b == "p") ? S_PRO1 : S_ERR;
            S_PRO1: r = (b == "h") ? S_PRO2 : S_ERR;
            S_PRO2: r = (b == "p") ? S_PRO3 : S_ERR;
            S_GREATER: r = (b == "=") ? S_GE : S_ERR;
            S_ASSIGN: r = (b == "=") ? S_EQ2 : S_ERR;
            S_EQ2: r = (b == "=") ? S_EQ3 : S_ERR;
            S_EXCL: r = (b == "=") ? S_NE2 : S_ERR;
            S_NE2: r = (b == "=") ? S_NE3 : S_ERR;
            default: r = S_ERR;
        endcase
        return r;
    endfunction

    // final flag in bit 6, kind in bits 5:0
    function automatic logic [6:0] state_kind(input scan_state_t s);
        logic [6:0] r;
        case (s)
            S_IDENT, S_TYPEID: r = {1'b1, K_ID};
            S_VAR_ID: r = {1'b1, 6'd1};
            S_LPAR: r = {1'b1, 6'd2};
            S_RPAR: r = {1'b1, 6'd3};
            S_LBR: r = {1'b1, 6'd4};
            S_RBR: r = {1'b1, 6'd5};
            S_COMMA: r = {1'b1, 6'd6};
            S_SEMI: r = {1'b1, 6'd7};
            S_COLON: r = {1'b1, 6'd8};
            S_MUL: r = {1'b1, 6'd9};
            S_DIV: r = {1'b1, 6'd10};
            S_PLUS: r = {1'b1, 6'd11};
            S_MINUS: r = {1'b1, 6'd12};
            S_GREATER: r = {1'b1, 6'd13};
            S_GE: r = {1'b1, 6'd14};
            S_LESS: r = {1'b1, 6'd15};
            S_LE: r = {1'b1, 6'd16};
            S_ASSIGN: r = {1'b1, 6'd17};
            S_EQ3: r = {1'b1, 6'd18};
            S_NE3: r = {1'b1, 6'd19};
            S_DOT: r = {1'b1, 6'd20};
            S_NUM: r = {1'b1, 6'd21};
            S_NUM_DEC, S_NUM_EXP: r = {1'b1, 6'd22};
            S_STR_END: r = {1'b1, 6'd23};
            S_PRO3: r = {1'b1, K_PROLOG};
            S_END: r = {1'b1, K_END};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_text_state(input scan_state_t s);
        return s inside {S_STR, S_STR_BSL, S_IDENT, S_TYPEID, S_VAR_ID, S_NUM,
                         S_NUM_DOT, S_NUM_DEC, S_NUM_E, S_NUM_ESIGN, S_NUM_EXP};
    endfunction

endpackage

// ===== rtl/sts_word_match.sv =====
`timescale 1ns / 1ps
module sts_word_match (
    input  sts_pkg::word_t                  word,
    input  logic [sts_pkg::WLEN_W-1:0]      length,
    output sts_pkg::word_match_t            keyword,
    output sts_pkg::word_match_t            opt_type
);
    import sts_pkg::*;

    localparam int NKW = 22;
    localparam int LITW = 12;

    typedef logic [LITW*8-1:0] lit_t;

    // literals left-aligned: character 0 in the top byte
    localparam lit_t KW [NKW] = '{
        {"else", 64'd0}, {"float", 56'd0}, {"function", 32'd0}, {"if", 80'd0},
        {"int", 72'd0}, {"null", 64'd0}, {"return", 48'd0}, {"string", 48'd0},
        {"void", 64'd0}, {"while", 56'd0}, {"declare", 40'd0}, {"strict", "_types"},
        {"reads", 56'd0}, {"readi", 56'd0}, {"readf", 56'd0}, {"floatval", 32'd0},
        {"intval", 48'd0}, {"write", 56'd0}, {"strlen", 48'd0}, {"substring", 24'd0},
        {"chr", 72'd0}, {"ord", 72'd0}
    };
    localparam logic [3:0] KWLEN [NKW] = '{
        4'd4, 4'd5, 4'd8, 4'd2, 4'd3, 4'd4, 4'd6, 4'd6, 4'd4, 4'd5, 4'd7, 4'd12,
        4'd5, 4'd5, 4'd5, 4'd8, 4'd6, 4'd5, 4'd6, 4'd9, 4'd3, 4'd3
    };
    localparam int OPT_IDX [3] = '{4, 1, 7};

    logic [NKW-1:0] hits;

    function automatic logic match(input word_t w, input logic [WLEN_W-1:0] n,
                                   input lit_t lit, input logic [3:0] ln);
        logic ok;
        ok = (n == WLEN_W'(ln));
        for (int c = 0; c < LITW; c++)
        begin
            if (c < int'(ln) && c < MAX_WORD_LEN)
            begin
                if (w[c*8 +: 8] != lit[(LITW-1-c)*8 +: 8]) ok = 1'b0;
            end
        end
        return ok;
    endfunction

    always_comb
    begin
        for (int i = 0; i < NKW; i++)
        begin
            hits[i] = match(word, length, KW[i], KWLEN[i]);
        end
        keyword = '0;
        for (int i = NKW - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                keyword.hit = 1'b1;
                keyword.index = 5'(i);
            end
        end
        opt_type = '0;
        for (int i = 2; i >= 0; i--)
        begin
            if (hits[OPT_IDX[i]])
            begin
                opt_type.hit = 1'b1;
                opt_type.index = 5'(i);
            end
        end
    end

endmodule

// ===== rtl/source_token_scanner_unit.sv =====
`timescale 1ns / 1ps
// Channel | Dir | tdata (low bit up)                | tuser
// s_axis  | in  | [7:0] source_byte                 | [0] end_of_input
// m_axis  | out | [0] token_valid [6:1] token_kind  | -
//         |     | [7] text_byte [8] scan_error      |
//         |     | [9] scan_done, [15:10] zero       |
// One byte per cycle while the output is not stalled: the incoming byte
// feeds the automaton, keyword match and framing checks, whose result
// lands in the output register at the accepting edge.
// Reset puts the automaton in its start state and clears all framing flags.
// A stalled output holds its result; input is taken whenever the output
// register is empty or is being drained in the same cycle.
module source_token_scanner_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
    input  logic        s_axis_tuser,   // [0] end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // valid, kind[6:1], text, error, done
);
    import sts_pkg::*;

    scan_state_t state_reg, state_next;
    word_t word_reg, word_next;
    logic [WLEN_W-1:0] wlen_reg, wlen_next;
    logic first_byte_reg, first_byte_next;
    logic first_tok_reg, first_tok_next;
    logic closing_reg, closing_next;
    logic failed_reg, failed_next;
    scan_result_t res_reg, res;
    logic out_valid_reg;
    logic take;
    word_match_t kw, opt;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign take = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {6'd0, res_reg.done, res_reg.err, res_reg.text,
                           res_reg.kind, res_reg.valid};

    sts_word_match u_match (
        .word     (word_reg),
        .length   (wlen_reg),
        .keyword  (kw),
        .opt_type (opt)
    );

    always_comb
    begin
        logic [7:0] b;
        logic ok;
        logic fin_ok;
        logic [6:0] sk;
        logic [5:0] k;
        scan_state_t nx;
        logic [WLEN_W-1:0] wl;

        b = s_axis_tdata;
        ok = 1'b1;
        res = '0;
        state_next = state_reg;
        word_next = word_reg;
        wlen_next = wlen_reg;
        first_byte_next = first_byte_reg;
        first_tok_next = first_tok_reg;
        closing_next = closing_reg;
        failed_next = failed_reg;
        nx = S_ERR;
        wl = wlen_reg;

        // finish the token of the current state
        sk = state_kind(state_reg);
        k = sk[5:0];
        fin_ok = sk[6];
        if (state_reg == S_END)
        begin
            fin_ok = first_tok_reg;
        end
        else if (sk[6])
        begin
            if (state_reg == S_IDENT && kw.hit) k = K_KEYWORD + 6'(kw.index);
            if (state_reg == S_TYPEID)
            begin
                if (opt.hit) k = K_OPT + 6'(opt.index);
                else fin_ok = 1'b0;
            end
            if (fin_ok && !first_tok_reg && k != K_PROLOG) fin_ok = 1'b0;
        end

        if (failed_reg)
        begin
            res.err = 1'b1;
        end
        else if (state_reg == S_DONE)
        begin
            res.done = 1'b1;
        end
        else if (s_axis_tuser)
        begin
            ok = first_byte_reg && !closing_reg;
            if (ok && !(state_reg inside {S_START, S_LINE_CMT, S_BLK_TEXT, S_BLK_STAR}))
            begin
                ok = fin_ok;
                if (state_reg == S_END) closing_next = 1'b1;
                else if (sk[6])
                begin
                    first_tok_next = 1'b1;
                    res.valid = 1'b1;
                    res.kind = k;
                end
            end
            if (ok && !(first_tok_reg || first_tok_next)) ok = 1'b0;
            if (ok)
            begin
                state_next = S_DONE;
                res.done = 1'b1;
            end
        end
        else
        begin
            if (!first_byte_reg)
            begin
                first_byte_next = 1'b1;
                if (b != "<") ok = 1'b0;
            end
            if (closing_reg || state_reg == S_END) ok = 1'b0;
            if (ok && state_reg == S_STR_BSL)
            begin
                res.text = 1'b1;
                if (b == "n" || b == "t" || b == 8'h5c || b == "\"" || b == "$") nx = S_STR;
                else nx = string_next(b);
                if (nx == S_ERR) ok = 1'b0;
                else state_next = nx;
            end
            else if (ok)
            begin
                if (state_reg == S_START) wl = '0;
                nx = trans(state_reg, b);
                if (nx == S_ERR)
                begin
                    if (!sk[6] || !fin_ok)
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        if (state_reg == S_END) closing_next = 1'b1;
                        else
                        begin
                            first_tok_next = 1'b1;
                            res.valid = 1'b1;
                            res.kind = k;
                        end
                        wl = '0;
                        nx = trans(S_START, b);
                        if (nx == S_ERR) ok = 1'b0;
                    end
                    res.text = is_text_state(nx);
                end
                else
                begin
                    res.text = is_text_state(state_reg) || is_text_state(nx);
                end
                if (ok)
                begin
                    state_next = nx;
                    wlen_next = wl;
                    if (nx == S_IDENT || nx == S_TYPEID)
                    begin
                        for (int i = 0; i < MAX_WORD_LEN; i++)
                        begin
                            if (wl == WLEN_W'(i)) word_next[i*8 +: 8] = b;
                        end
                        if (wl <= WLEN_W'(MAX_WORD_LEN)) wlen_next = wl + 1'b1;
                    end
                end
            end
        end

        if (!ok)
        begin
            failed_next = 1'b1;
            res = '0;
            res.err = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_START;
            wlen_reg <= '0;
            first_byte_reg <= 1'b0;
            first_tok_reg <= 1'b0;
            closing_reg <= 1'b0;
            failed_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg <= state_next;
                wlen_reg <= wlen_next;
                first_byte_reg <= first_byte_next;
                first_tok_reg <= first_tok_next;
                closing_reg <= closing_next;
                failed_reg <= failed_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: word store and result hold without reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= word_next;
            res_reg <= res;
        end
    end

endmodule
